// ----- rtl/orwl_pkg.sv -----
// Package for the overwriting record ring with offset lookup.
// Holds the depth constant, the command and response structs and the cell structs.
// No dependencies; imported by orwl_cell and the top level.
package orwl_pkg;

	// Ring depth and slot tag width
	localparam int DEPTH  = 16;
	localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// Command kinds
	localparam logic KIND_ADD  = 1'b0;
	localparam logic KIND_FIND = 1'b1;

	// Command transaction
	typedef struct packed {
		logic        kind;
		logic [31:0] entry_handle;
		logic [15:0] add_size;
		logic [19:0] byte_pos;
	} req_t;

	// Response transaction
	typedef struct packed {
		logic        found;
		logic [3:0]  slot_index;
		logic [31:0] found_handle;
		logic [15:0] found_size;
		logic [15:0] byte_within;
	} rsp_t;

	// Record held by one cell and shifted to its neighbor on an add
	typedef struct packed {
		logic              valid;
		logic [SLOT_W-1:0] slot;
		logic [31:0]       handle;
		logic [15:0]       size;
	} rec_t;

	// Lookup token walking the chain from oldest to newest record
	typedef struct packed {
		logic              valid;
		logic              hit;
		logic [19:0]       remaining;
		logic [SLOT_W-1:0] slot;
		logic [31:0]       handle;
		logic [15:0]       size;
		logic [15:0]       in_ofs;
	} tok_t;

endpackage

// ----- rtl/orwl_cell.sv -----
// One cell of the record chain: holds one record and one stage of the lookup token.
// Records shift toward higher cells on an add; the token moves toward cell 0 each cycle.
// Depends on orwl_pkg.
module orwl_cell
	import orwl_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic shift_en,
	input  rec_t rec_in,
	output rec_t rec_out,
	input  tok_t tok_in,
	output tok_t tok_out
);

	logic              rec_valid_q;
	logic [SLOT_W-1:0] rec_slot_q;
	logic [31:0]       rec_handle_q;
	logic [15:0]       rec_size_q;
	logic              tok_valid_q;
	tok_t              tok_q;
	tok_t              tok_nxt;
	logic              probe;
	logic              match;

	// Record storage: valid bit is reset, payload is not
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_valid_q <= 1'b0;
		end else if (shift_en) begin
			rec_valid_q <= rec_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			rec_slot_q   <= rec_in.slot;
			rec_handle_q <= rec_in.handle;
			rec_size_q   <= rec_in.size;
		end
	end

	assign rec_out = '{valid: rec_valid_q, slot: rec_slot_q, handle: rec_handle_q,
		size: rec_size_q};

	// Token step: match when the remaining offset falls inside this record,
	// otherwise charge this record's size against the offset
	assign probe = tok_in.valid && !tok_in.hit && rec_valid_q;
	assign match = probe && (tok_in.remaining < {4'b0, rec_size_q});

	always_comb begin
		tok_nxt = tok_in;
		if (match) begin
			tok_nxt.hit    = 1'b1;
			tok_nxt.slot   = rec_slot_q;
			tok_nxt.handle = rec_handle_q;
			tok_nxt.size   = rec_size_q;
			tok_nxt.in_ofs = tok_in.remaining[15:0];
		end else if (probe) begin
			tok_nxt.remaining = tok_in.remaining - {4'b0, rec_size_q};
		end
	end

	// Token register: valid is reset, payload is not
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_q <= 1'b0;
		end else begin
			tok_valid_q <= tok_nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_nxt;
	end

	always_comb begin
		tok_out       = tok_q;
		tok_out.valid = tok_valid_q;
	end

endmodule

// ----- rtl/overwriting_ring_with_offset_lookup.sv -----
// Add: no response; busy stays low, so a new command may follow in the next cycle.
// Find: the token crosses the DEPTH-cell chain one cell per cycle, entering at cell DEPTH-1
// and ending at cell 0, where done rises with the response. busy is high, and no command is
// accepted, until the token reaches cell 0. The receiver cannot stall.
// Async active-low reset empties the ring and drops any lookup in flight; no clearing pass.
// Top level: chain of orwl_cell records plus write slot counter; depends on orwl_pkg, orwl_cell.
module overwriting_ring_with_offset_lookup
	import orwl_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	logic [SLOT_W-1:0] write_slot_q;
	logic              do_add;
	logic              do_find;
	rec_t              rec_in   [DEPTH];
	rec_t              rec_out  [DEPTH];
	tok_t              tok_in   [DEPTH];
	tok_t              tok_out  [DEPTH];
	logic [DEPTH-1:0]  tok_busy;

	assign do_add  = start && !busy && (req.kind == KIND_ADD);
	assign do_find = start && !busy && (req.kind == KIND_FIND);

	// Write slot counter, wraps at DEPTH
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_slot_q <= '0;
		end else if (do_add) begin
			if (write_slot_q == SLOT_W'(DEPTH - 1)) begin
				write_slot_q <= '0;
			end else begin
				write_slot_q <= write_slot_q + SLOT_W'(1);
			end
		end
	end

	// Cell chain: cell 0 holds the newest record, the oldest sits highest
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign rec_in[i] = '{valid: 1'b1, slot: write_slot_q,
				handle: req.entry_handle, size: req.add_size};
		end else begin : g_link
			assign rec_in[i] = rec_out[i-1];
		end

		if (i == DEPTH - 1) begin : g_inject
			assign tok_in[i] = '{valid: do_find, hit: 1'b0, remaining: req.byte_pos,
				slot: '0, handle: '0, size: '0, in_ofs: '0};
		end else begin : g_pass
			assign tok_in[i] = tok_out[i+1];
		end

		orwl_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (do_add),
			.rec_in   (rec_in[i]),
			.rec_out  (rec_out[i]),
			.tok_in   (tok_in[i]),
			.tok_out  (tok_out[i])
		);

		assign tok_busy[i] = tok_out[i].valid;
	end

	// Busy while the token is still upstream of the last cell
	assign busy = |tok_busy[DEPTH-1:1];

	// Response from the last cell of the walk
	assign done             = tok_out[0].valid;
	assign rsp.found        = tok_out[0].hit;
	assign rsp.slot_index   = 4'(tok_out[0].slot);
	assign rsp.found_handle = tok_out[0].handle;
	assign rsp.found_size   = tok_out[0].size;
	assign rsp.byte_within  = tok_out[0].in_ofs;

	// Checks
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(tok_busy) <= 1)
		else $error("more than one lookup token in the chain");

	a_find_busy: assert property (@(posedge clk) disable iff (!arst_n)
		do_find |=> busy)
		else $error("busy not raised after a find was accepted");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("response strobe while the chain is still busy");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !rsp.found) |-> (rsp.slot_index == 4'd0 && rsp.found_handle == 32'd0
			&& rsp.found_size == 16'd0 && rsp.byte_within == 16'd0))
		else $error("not-found response carries nonzero fields");

	a_add_head: assert property (@(posedge clk) disable iff (!arst_n)
		do_add |=> rec_out[0].valid)
		else $error("head cell not valid after an add");

endmodule
